// File: sv/dhss_pkg.sv
package dhss_pkg;

  localparam int unsigned MAX_SLOTS     = 1024;
  localparam int unsigned INIT_SLOTS    = 8;
  localparam int unsigned MAX_KEY_CHARS = 8;

  localparam int unsigned IDX_W  = $clog2(MAX_SLOTS);
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned LOG_W  = 4;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned CHI_W  = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;

  localparam int unsigned INIT_LOG_RAW = $clog2(INIT_SLOTS + 1) - 1;
  localparam int unsigned INIT_LOG     = (INIT_LOG_RAW > IDX_W) ? IDX_W : INIT_LOG_RAW;

  localparam int unsigned HMUL1 = 37;
  localparam int unsigned HMUL2 = 137;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  typedef struct packed {
    logic              st_we;
    logic              kl_we;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        st;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
  } tbl_wr_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_GROW, S_SHRINK, S_RH_CLR, S_RH_RD, S_RH_CHK,
    S_RH_HASH, S_RH_PRD, S_RH_PCHK, S_RH_END, S_HASH, S_PRD, S_PCHK, S_DONE
  } fsm_e;

endpackage

// File: sv/dhss_hash.sv
// Iterative Horner hash pair, one character per cycle.
module dhss_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dhss_pkg::KEY_W-1:0]  key_i,
  input  logic [dhss_pkg::LEN_W-1:0]  len_i,
  input  logic [dhss_pkg::LOG_W-1:0]  log_i,
  output logic                        done_o,
  output logic [dhss_pkg::IDX_W-1:0]  h1_o,
  output logic [dhss_pkg::IDX_W-1:0]  step_o
);
  localparam int unsigned IW = dhss_pkg::IDX_W;
  localparam int unsigned SW = IW + 9;

  logic                       busy_q;
  logic [IW-1:0]              a_q, b_q, mask_q;
  logic [dhss_pkg::LEN_W-1:0] cnt_q, len_q;
  logic [dhss_pkg::KEY_W-1:0] key_q;
  logic [dhss_pkg::CHI_W+2:0] bitpos;
  logic [7:0]                 c;
  logic [SW-1:0]              a_sum, b_sum;
  logic [IW-1:0]              mask_in;

  assign bitpos  = {cnt_q[dhss_pkg::CHI_W-1:0], 3'b000};
  assign c       = key_q[bitpos +: 8];
  assign a_sum   = SW'(a_q) * SW'(dhss_pkg::HMUL1) + SW'(c);
  assign b_sum   = SW'(b_q) * SW'(dhss_pkg::HMUL2) + SW'(c);
  assign mask_in = IW'((dhss_pkg::CNT_W'(1) << log_i) - dhss_pkg::CNT_W'(1));

  assign done_o = busy_q && (cnt_q == len_q);
  assign h1_o   = a_q;
  assign step_o = {b_q[IW-2:0], 1'b1} & mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      len_q  <= len_i;
      key_q  <= key_i;
      mask_q <= mask_in;
    end else if (busy_q && !done_o) begin
      a_q   <= a_sum[IW-1:0] & mask_q;
      b_q   <= b_sum[IW-1:0] & mask_q;
      cnt_q <= cnt_q + 1'b1;
    end
  end

endmodule

// File: sv/dhss_table.sv
// Slot store for both banks: status and key/length, registered read.
module dhss_table (
  input  logic                        clk_i,
  input  logic [dhss_pkg::ADDR_W-1:0] rd_addr_i,
  input  dhss_pkg::tbl_wr_t           wr_i,
  output logic [1:0]                  rd_st_o,
  output logic [dhss_pkg::KEY_W-1:0]  rd_key_o,
  output logic [dhss_pkg::LEN_W-1:0]  rd_len_o
);
  localparam int unsigned DEPTH = 2 * dhss_pkg::MAX_SLOTS;

  logic [1:0]                                    st_mem [DEPTH];
  logic [dhss_pkg::KEY_W+dhss_pkg::LEN_W-1:0]    kl_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.st_we) begin
      st_mem[wr_i.addr] <= wr_i.st;
    end
    rd_st_o <= st_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.kl_we) begin
      kl_mem[wr_i.addr] <= {wr_i.key, wr_i.len};
    end
    {rd_key_o, rd_len_o} <= kl_mem[rd_addr_i];
  end

endmodule

// File: sv/double_hash_string_set.sv
// Open-addressed set of keys of up to eight bytes with double hashing. Each
// accepted beat is a lookup, insert or delete (other commands give ok low)
// and returns one beat with ok. The block works on one beat at a time;
// in_ready_o is high only while idle. A lookup or delete hashes then probes,
// an insert first makes its load checks: the Horner hash unit takes one
// character a cycle and each probe is a read and a check on the slot memory.
// An insert that crosses 3/4 load, or finds more than half the table
// tombstoned, first rehashes into the other bank: a clear of that bank, a
// read and a check per old slot and a hash plus probes per live key. After
// reset a clearing pass over both banks runs before the first beat is taken.
// A result waits in an output register while the next beat is accepted.
module double_hash_string_set_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [dhss_pkg::KEY_W-1:0]  key_i,
  input  logic [dhss_pkg::LEN_W-1:0]  key_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o
);
  localparam int unsigned IW = dhss_pkg::IDX_W;
  localparam int unsigned AW = dhss_pkg::ADDR_W;
  localparam int unsigned CW = dhss_pkg::CNT_W;
  localparam int unsigned LW = dhss_pkg::LOG_W;
  localparam int unsigned KW = dhss_pkg::KEY_W;
  localparam int unsigned NW = dhss_pkg::LEN_W;

  dhss_pkg::fsm_e state_q, state_d;

  logic [1:0]    cmd_q, cmd_d;
  logic [KW-1:0] key_q, key_d, rk_q, rk_d;
  logic [NW-1:0] len_q, len_d, rl_q, rl_d;
  logic          bank_q, bank_d;
  logic [LW-1:0] slog_q, slog_d, nlog_q, nlog_d;
  logic [CW-1:0] live_q, live_d, tomb_q, tomb_d;
  logic [AW-1:0] j_q, j_d;
  logic [IW-1:0] h_q, h_d, step_q, step_d, pc_q, pc_d, tgt_q, tgt_d;
  logic          tgt_v_q, tgt_v_d, res_q, res_d;
  logic          out_valid_q, out_valid_d, ok_q, ok_d;

  // input conditioning: clamp length, zero bytes past it
  logic [NW-1:0] len_c;
  logic [KW-1:0] key_c;
  always_comb begin
    len_c = (key_len_i > NW'(dhss_pkg::MAX_KEY_CHARS)) ? NW'(dhss_pkg::MAX_KEY_CHARS)
                                                        : key_len_i;
    for (int b = 0; b < KW / 8; b++) begin
      key_c[8*b +: 8] = (NW'(b) < len_c) ? key_i[8*b +: 8] : 8'h00;
    end
  end

  // table size terms
  logic [CW-1:0]   m_c;
  logic [IW-1:0]   mask_c, nmask_c;
  logic [CW+1:0]   load4, cap3;
  logic            grow_c, shr_c;
  assign m_c     = CW'(1) << slog_q;
  assign mask_c  = IW'(m_c - CW'(1));
  assign nmask_c = IW'((CW'(1) << nlog_q) - CW'(1));
  assign load4   = {live_q, 2'b00};
  assign cap3    = {1'b0, m_c, 1'b0} + {2'b00, m_c};
  assign grow_c  = (load4 >= cap3) && (slog_q < LW'(IW));
  assign shr_c   = ({tomb_q, 1'b0} > {1'b0, m_c}) && (slog_q != '0);

  // hash unit
  logic          hs_start, hs_done;
  logic [KW-1:0] hs_key;
  logic [NW-1:0] hs_len;
  logic [LW-1:0] hs_log;
  logic [IW-1:0] hs_h1, hs_step;

  dhss_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hs_start),
    .key_i   (hs_key),
    .len_i   (hs_len),
    .log_i   (hs_log),
    .done_o  (hs_done),
    .h1_o    (hs_h1),
    .step_o  (hs_step)
  );

  // slot store
  logic [AW-1:0]     rd_addr;
  dhss_pkg::tbl_wr_t wr;
  logic [1:0]        rd_st;
  logic [KW-1:0]     rd_key;
  logic [NW-1:0]     rd_len;

  dhss_table u_table (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_st_o   (rd_st),
    .rd_key_o  (rd_key),
    .rd_len_o  (rd_len)
  );

  logic rd_empty, rd_live, rd_tomb, rd_match, p_last, old_last, is_ins;
  assign rd_empty = (rd_st == dhss_pkg::ST_EMPTY);
  assign rd_live  = (rd_st == dhss_pkg::ST_LIVE);
  assign rd_tomb  = !rd_empty && !rd_live;
  assign rd_match = rd_live && (rd_len == len_q) && (rd_key == key_q);
  assign p_last   = (pc_q == mask_c);
  assign old_last = (j_q[IW-1:0] == mask_c);
  assign is_ins   = (cmd_q == dhss_pkg::CMD_INSERT);

  assign in_ready_o  = (state_q == dhss_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhss_pkg::S_CLR:     if (&j_q) state_d = dhss_pkg::S_IDLE;
      dhss_pkg::S_IDLE:    if (in_valid_i) state_d = dhss_pkg::S_DISP;
      dhss_pkg::S_DISP: begin
        if (cmd_q == dhss_pkg::CMD_LOOKUP || cmd_q == dhss_pkg::CMD_DELETE) begin
          state_d = dhss_pkg::S_HASH;
        end else if (is_ins) begin
          state_d = dhss_pkg::S_GROW;
        end else begin
          state_d = dhss_pkg::S_DONE;
        end
      end
      dhss_pkg::S_GROW:    state_d = grow_c ? dhss_pkg::S_RH_CLR : dhss_pkg::S_SHRINK;
      dhss_pkg::S_SHRINK:  state_d = shr_c ? dhss_pkg::S_RH_CLR : dhss_pkg::S_HASH;
      dhss_pkg::S_RH_CLR:  if (&j_q[IW-1:0]) state_d = dhss_pkg::S_RH_RD;
      dhss_pkg::S_RH_RD:   state_d = dhss_pkg::S_RH_CHK;
      dhss_pkg::S_RH_CHK: begin
        if (rd_live) begin
          state_d = dhss_pkg::S_RH_HASH;
        end else begin
          state_d = old_last ? dhss_pkg::S_RH_END : dhss_pkg::S_RH_RD;
        end
      end
      dhss_pkg::S_RH_HASH: if (hs_done) state_d = dhss_pkg::S_RH_PRD;
      dhss_pkg::S_RH_PRD:  state_d = dhss_pkg::S_RH_PCHK;
      dhss_pkg::S_RH_PCHK: begin
        if (!rd_empty) begin
          state_d = dhss_pkg::S_RH_PRD;
        end else begin
          state_d = old_last ? dhss_pkg::S_RH_END : dhss_pkg::S_RH_RD;
        end
      end
      // after any rehash tomb count is zero, so the shrink check falls through
      dhss_pkg::S_RH_END:  state_d = dhss_pkg::S_SHRINK;
      dhss_pkg::S_HASH:    if (hs_done) state_d = dhss_pkg::S_PRD;
      dhss_pkg::S_PRD:     state_d = dhss_pkg::S_PCHK;
      dhss_pkg::S_PCHK: begin
        if (rd_empty || rd_match || p_last) begin
          state_d = dhss_pkg::S_DONE;
        end else begin
          state_d = dhss_pkg::S_PRD;
        end
      end
      dhss_pkg::S_DONE:    if (!out_valid_q || out_ready_i) state_d = dhss_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d = cmd_q;  key_d = key_q;  len_d = len_q;
    rk_d = rk_q;    rl_d = rl_q;
    bank_d = bank_q; slog_d = slog_q; nlog_d = nlog_q;
    live_d = live_q; tomb_d = tomb_q;
    j_d = j_q; h_d = h_q; step_d = step_q; pc_d = pc_q;
    tgt_d = tgt_q; tgt_v_d = tgt_v_q; res_d = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d = ok_q;
    hs_start = 1'b0;
    hs_key = key_q;
    hs_len = len_q;
    hs_log = slog_q;
    rd_addr = {bank_q, h_q};
    wr = '0;
    wr.key = key_q;
    wr.len = len_q;

    unique case (state_q)
      dhss_pkg::S_CLR: begin
        wr.st_we = 1'b1;
        wr.addr  = j_q;
        wr.st    = dhss_pkg::ST_EMPTY;
        j_d      = j_q + 1'b1;
      end
      dhss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          key_d = key_c;
          len_d = len_c;
        end
      end
      dhss_pkg::S_DISP: begin
        if (cmd_q == dhss_pkg::CMD_LOOKUP || cmd_q == dhss_pkg::CMD_DELETE) begin
          hs_start = 1'b1;
        end else if (!is_ins) begin
          res_d = 1'b0;
        end
      end
      dhss_pkg::S_GROW: begin
        if (grow_c) begin
          nlog_d = slog_q + 1'b1;
          j_d    = '0;
        end
      end
      dhss_pkg::S_SHRINK: begin
        if (shr_c) begin
          nlog_d = slog_q - 1'b1;
          j_d    = '0;
        end else begin
          hs_start = 1'b1;
        end
      end
      dhss_pkg::S_RH_CLR: begin
        wr.st_we = 1'b1;
        wr.addr  = {~bank_q, j_q[IW-1:0]};
        wr.st    = dhss_pkg::ST_EMPTY;
        if (&j_q[IW-1:0]) begin
          j_d    = '0;
          live_d = '0;
          tomb_d = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      dhss_pkg::S_RH_RD: begin
        rd_addr = {bank_q, j_q[IW-1:0]};
      end
      dhss_pkg::S_RH_CHK: begin
        if (rd_live) begin
          hs_start = 1'b1;
          hs_key   = rd_key;
          hs_len   = rd_len;
          hs_log   = nlog_q;
          rk_d     = rd_key;
          rl_d     = rd_len;
        end else if (!old_last) begin
          j_d = j_q + 1'b1;
        end
      end
      dhss_pkg::S_RH_HASH: begin
        if (hs_done) begin
          h_d    = hs_h1;
          step_d = hs_step;
        end
      end
      dhss_pkg::S_RH_PRD: begin
        rd_addr = {~bank_q, h_q};
      end
      dhss_pkg::S_RH_PCHK: begin
        if (rd_empty) begin
          wr.st_we = 1'b1;
          wr.kl_we = 1'b1;
          wr.addr  = {~bank_q, h_q};
          wr.st    = dhss_pkg::ST_LIVE;
          wr.key   = rk_q;
          wr.len   = rl_q;
          live_d   = live_q + 1'b1;
          if (!old_last) j_d = j_q + 1'b1;
        end else begin
          h_d = (h_q + step_q) & nmask_c;
        end
      end
      dhss_pkg::S_RH_END: begin
        bank_d = ~bank_q;
        slog_d = nlog_q;
      end
      dhss_pkg::S_HASH: begin
        if (hs_done) begin
          h_d     = hs_h1;
          step_d  = hs_step;
          pc_d    = '0;
          tgt_v_d = 1'b0;
        end
      end
      dhss_pkg::S_PRD: begin
        rd_addr = {bank_q, h_q};
      end
      dhss_pkg::S_PCHK: begin
        priority if (rd_empty) begin
          res_d = is_ins;
          if (is_ins) begin
            wr.st_we = 1'b1;
            wr.kl_we = 1'b1;
            wr.addr  = {bank_q, tgt_v_q ? tgt_q : h_q};
            wr.st    = dhss_pkg::ST_LIVE;
            live_d   = live_q + 1'b1;
            if (tgt_v_q && tomb_q != '0) tomb_d = tomb_q - 1'b1;
          end
        end else if (rd_match) begin
          res_d = !is_ins;
          if (cmd_q == dhss_pkg::CMD_DELETE) begin
            wr.st_we = 1'b1;
            wr.addr  = {bank_q, h_q};
            wr.st    = dhss_pkg::ST_TOMB;
            live_d   = live_q - 1'b1;
            tomb_d   = tomb_q + 1'b1;
          end
        end else begin
          if (is_ins && rd_tomb && !tgt_v_q) begin
            tgt_d   = h_q;
            tgt_v_d = 1'b1;
          end
          if (p_last) begin
            // chain exhausted: insert takes the first tombstone seen, if any
            res_d = is_ins && (tgt_v_q || rd_tomb);
            if (is_ins && (tgt_v_q || rd_tomb)) begin
              wr.st_we = 1'b1;
              wr.kl_we = 1'b1;
              wr.addr  = {bank_q, tgt_v_q ? tgt_q : h_q};
              wr.st    = dhss_pkg::ST_LIVE;
              live_d   = live_q + 1'b1;
              if (tomb_q != '0) tomb_d = tomb_q - 1'b1;
            end
          end else begin
            h_d  = (h_q + step_q) & mask_c;
            pc_d = pc_q + 1'b1;
          end
        end
      end
      dhss_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ok_d        = res_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dhss_pkg::S_CLR;
      bank_q      <= 1'b0;
      slog_q      <= LW'(dhss_pkg::INIT_LOG);
      live_q      <= '0;
      tomb_q      <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      slog_q      <= slog_d;
      live_q      <= live_d;
      tomb_q      <= tomb_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    len_q   <= len_d;
    rk_q    <= rk_d;
    rl_q    <= rl_d;
    nlog_q  <= nlog_d;
    h_q     <= h_d;
    step_q  <= step_d;
    pc_q    <= pc_d;
    tgt_q   <= tgt_d;
    tgt_v_q <= tgt_v_d;
    res_q   <= res_d;
    ok_q    <= ok_d;
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import dhss_pkg::*;

  localparam int unsigned NUM_RAND   = 700;
  localparam int unsigned POOL_N     = 48;
  localparam int unsigned DRAIN_AT   = 380;   // sender waits for an empty pipe here
  localparam int unsigned HOLD_AT    = 120;   // receiver long hold-off at this result
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned CYCLE_CAP  = 600000;

  typedef struct {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } op_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       cmd_i;
  logic [KEY_W-1:0] key_i;
  logic [LEN_W-1:0] key_len_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             ok_o;

  double_hash_string_set_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .key_len_i   (key_len_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the set: two banks, per-slot state, live/tomb counters.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] shd_key   [2*MAX_SLOTS];
  logic [LEN_W-1:0] shd_len   [2*MAX_SLOTS];
  logic [1:0]       shd_state [2*MAX_SLOTS];
  int unsigned      shd_bank;
  int unsigned      shd_log;
  int unsigned      shd_live;
  int unsigned      shd_tomb;

  op_t         ops_q[$];      // beats waiting to be offered
  logic        ok_exp_q[$];   // predicted ok per accepted beat
  int unsigned nxt_op;
  int unsigned n_res;
  int unsigned n_err;
  int unsigned cyc;

  function automatic int unsigned log_cap();
    return $clog2(MAX_SLOTS);
  endfunction

  function automatic int unsigned slot_ix(int unsigned bank, int unsigned idx);
    return (bank & 1) * MAX_SLOTS + idx;
  endfunction

  // Horner home slot and odd probe step, both reduced by the table mask.
  function automatic void horner(logic [KEY_W-1:0] k, int unsigned len, int unsigned mask,
                                 output int unsigned home, output int unsigned step);
    int unsigned a;
    int unsigned b;
    int unsigned c;
    a = 0;
    b = 0;
    for (int i = 0; i < len; i++) begin
      c = (k >> (8 * i)) & 8'hff;
      a = (a * HMUL1 + c) & mask;
      b = (b * HMUL2 + c) & mask;
    end
    home = a;
    step = (2 * b + 1) & mask;
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] k, int unsigned len);
    int unsigned m;
    int unsigned h;
    int unsigned st;
    int unsigned s;
    m = 1 << shd_log;
    horner(k, len, m - 1, h, st);
    for (int unsigned i = 0; i < m; i++) begin
      s = slot_ix(shd_bank, h);
      if (shd_state[s] == ST_EMPTY) return -1;
      if (shd_state[s] == ST_LIVE && shd_len[s] == len && shd_key[s] == k) return s;
      h = (h + st) & (m - 1);
    end
    return -1;
  endfunction

  // Move every live key into the cleared other bank at the new size.
  function automatic void rebuild(int unsigned new_log);
    int unsigned ob;
    int unsigned nb;
    int unsigned old_m;
    int unsigned m;
    int unsigned o;
    int unsigned h;
    int unsigned st;
    int unsigned s;
    ob = shd_bank;
    nb = shd_bank ^ 1;
    old_m = 1 << shd_log;
    m = 1 << new_log;
    for (int unsigned j = 0; j < MAX_SLOTS; j++) shd_state[slot_ix(nb, j)] = ST_EMPTY;
    shd_live = 0;
    shd_tomb = 0;
    for (int unsigned j = 0; j < old_m; j++) begin
      o = slot_ix(ob, j);
      if (shd_state[o] == ST_LIVE) begin
        horner(shd_key[o], shd_len[o], m - 1, h, st);
        for (int unsigned i = 0; i < m; i++) begin
          s = slot_ix(nb, h);
          if (shd_state[s] == ST_EMPTY) begin
            shd_key[s] = shd_key[o];
            shd_len[s] = shd_len[o];
            shd_state[s] = ST_LIVE;
            shd_live++;
            break;
          end
          h = (h + st) & (m - 1);
        end
      end
    end
    shd_bank = nb;
    shd_log = new_log;
  endfunction

  function automatic logic add_key(logic [KEY_W-1:0] k, int unsigned len);
    int unsigned m;
    int unsigned h;
    int unsigned st;
    int unsigned s;
    int tgt;
    tgt = -1;
    m = 1 << shd_log;
    if (shd_live * 4 >= 3 * m && shd_log < log_cap()) rebuild(shd_log + 1);
    m = 1 << shd_log;
    if (shd_tomb * 2 > m && shd_log > 0) rebuild(shd_log - 1);
    m = 1 << shd_log;
    horner(k, len, m - 1, h, st);
    for (int unsigned i = 0; i < m; i++) begin
      s = slot_ix(shd_bank, h);
      if (shd_state[s] == ST_EMPTY) begin
        if (tgt < 0) tgt = s;
        break;
      end
      if (shd_state[s] == ST_LIVE) begin
        if (shd_len[s] == len && shd_key[s] == k) return 1'b0;
      end else if (tgt < 0) begin
        tgt = s;
      end
      h = (h + st) & (m - 1);
    end
    if (tgt < 0) return 1'b0;
    if (shd_state[tgt] == ST_TOMB && shd_tomb > 0) shd_tomb--;
    shd_key[tgt] = k;
    shd_len[tgt] = len;
    shd_state[tgt] = ST_LIVE;
    shd_live++;
    return 1'b1;
  endfunction

  // Predicted ok for one accepted beat; updates the shadow table.
  function automatic logic set_op_ok(op_t op);
    int unsigned len;
    logic [KEY_W-1:0] k;
    int s;
    len = (op.len > MAX_KEY_CHARS) ? MAX_KEY_CHARS : op.len;
    k = op.key;
    if (len < 8) k = k & ((64'd1 << (8 * len)) - 64'd1);
    case (op.cmd)
      CMD_LOOKUP: return find_slot(k, len) >= 0;
      CMD_INSERT: return add_key(k, len);
      CMD_DELETE: begin
        s = find_slot(k, len);
        if (s < 0) return 1'b0;
        shd_state[s] = ST_TOMB;
        shd_live--;
        shd_tomb++;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time from ops_q, with a random gap after each beat.
  // ---------------------------------------------------------------------------
  int unsigned tx_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= CMD_LOOKUP;
      key_i      <= '0;
      key_len_i  <= '0;
      tx_gap     = 0;
      nxt_op     = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        ok_exp_q.push_back(set_op_ok(ops_q[nxt_op]));
        nxt_op++;
        // every third stretch of 100 beats runs back to back
        tx_gap = ((nxt_op / 100) % 3 == 0) ? 0 : $urandom_range(0, 5);
        if (tx_gap > 0) begin
          in_valid_i <= 1'b0;
          tx_gap--;
        end else if (nxt_op < ops_q.size() && nxt_op != DRAIN_AT) begin
          cmd_i      <= ops_q[nxt_op].cmd;
          key_i      <= ops_q[nxt_op].key;
          key_len_i  <= ops_q[nxt_op].len;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (nxt_op < ops_q.size() &&
                     !(nxt_op == DRAIN_AT && ok_exp_q.size() != 0)) begin
          cmd_i      <= ops_q[nxt_op].cmd;
          key_i      <= ops_q[nxt_op].key;
          key_len_i  <= ops_q[nxt_op].len;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks ok against the oldest prediction, stalls at random per beat,
  // and once holds ready low long enough to back the block up.
  // ---------------------------------------------------------------------------
  int unsigned rx_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall    = 0;
      n_res       = 0;
      n_err       = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (ok_exp_q.size() == 0) begin
          $error("unexpected result beat: ok=%0b", ok_o);
          n_err++;
        end else begin
          if (ok_o !== ok_exp_q[0]) begin
            $error("field ok: expected %0b, actual %0b", ok_exp_q[0], ok_o);
            n_err++;
          end
          void'(ok_exp_q.pop_front());
        end
        n_res++;
        if (n_res == HOLD_AT) rx_stall = HOLD_LEN;
        else rx_stall = ((n_res / 100) % 3 == 1) ? 0 : $urandom_range(0, 5);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] word_of(int unsigned len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'h61 + $urandom_range(0, 5);
    return k;
  endfunction

  task automatic add_op(logic [1:0] c, logic [KEY_W-1:0] k, logic [LEN_W-1:0] l);
    op_t op;
    op.cmd = c;
    op.key = k;
    op.len = l;
    ops_q.push_back(op);
  endtask

  logic [KEY_W-1:0] pool_key [POOL_N];
  logic [LEN_W-1:0] pool_len [POOL_N];

  initial begin
    logic [KEY_W-1:0] k;
    logic [LEN_W-1:0] l;
    logic [1:0]       c;
    int unsigned      p;
    int unsigned      r;

    cyc = 0;
    rst_ni = 1'b0;
    for (int i = 0; i < 2*MAX_SLOTS; i++) shd_state[i] = ST_EMPTY;
    shd_bank = 0;
    shd_log  = INIT_LOG;
    shd_live = 0;
    shd_tomb = 0;

    // directed
    add_op(CMD_LOOKUP, 64'h61, 4'd1);                  // miss on empty table
    add_op(CMD_INSERT, 64'h61, 4'd1);
    add_op(CMD_INSERT, 64'h61, 4'd1);                  // duplicate
    add_op(CMD_LOOKUP, 64'hffff_ff00_0000_0061, 4'd1); // garbage above key_len
    add_op(CMD_DELETE, 64'h61, 4'd1);
    add_op(CMD_DELETE, 64'h61, 4'd1);                  // only live slots match
    add_op(CMD_LOOKUP, 64'h61, 4'd1);
    add_op(CMD_INSERT, 64'h61, 4'd1);                  // reuses the tombstone
    add_op(CMD_INSERT, 64'h1234, 4'd0);                // empty key
    add_op(CMD_LOOKUP, 64'd0, 4'd0);
    add_op(CMD_INSERT, '1, 4'd8);
    add_op(CMD_LOOKUP, '1, 4'd15);                     // long length clamps to 8
    add_op(CMD_INSERT, 64'd0, 4'd8);                   // zero bytes, length 8
    add_op(CMD_LOOKUP, 64'd0, 4'd7);
    add_op(2'd3, 64'h61, 4'd1);                        // unknown command
    add_op(CMD_DELETE, '1, 4'd9);
    add_op(CMD_LOOKUP, '1, 4'd8);
    for (int i = 0; i < 6; i++) add_op(CMD_INSERT, word_of(i + 2), i + 2); // grow past 3/4

    for (int i = 0; i < POOL_N; i++) begin
      pool_len[i] = $urandom_range(1, 8);
      pool_key[i] = word_of(pool_len[i]);
    end

    for (int i = 0; i < NUM_RAND; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 45) ? CMD_INSERT : (r < 70) ? CMD_LOOKUP : (r < 96) ? CMD_DELETE : 2'd3;
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, POOL_N - 1);
        k = pool_key[p];
        l = pool_len[p];
        if ($urandom_range(0, 2) == 0 && l < 8)
          k = k | ({$urandom, $urandom} & ~((64'd1 << (8 * l)) - 64'd1));
        if (l == 8 && $urandom_range(0, 3) == 0) l = $urandom_range(9, 15);
      end else begin
        k = {$urandom, $urandom};
        l = $urandom_range(0, 15);
      end
      add_op(c, k, l);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (nxt_op == ops_q.size() && ok_exp_q.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (n_err == 0 && ok_exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
